>>> sv/mnee_pkg.sv
// Package for the MIDI note event encoder: widths, byte constants, FSM and
// byte-select enums, and the controller/datapath command and status structs.
// No dependencies.
package mnee_pkg;

    localparam int MNEE_CHANNEL_COUNT = 16;
    localparam int TIME_W             = 28;
    localparam int INSTR_W            = 8;
    localparam int NOTE_W             = 7;
    localparam int COUNT_W            = 15;
    localparam int TOTAL_W            = 32;
    localparam int GRP_W              = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = 15'h7fff;
    localparam logic [7:0]         STAT_PROGRAM  = 8'hc0;
    localparam logic [7:0]         STAT_NOTE_ON  = 8'h90;
    localparam logic [7:0]         META_PREFIX   = 8'hff;
    localparam logic [7:0]         META_END_TRK  = 8'h2f;
    localparam logic [7:0]         BYTE_ZERO     = 8'h00;
    localparam logic [7:0]         VLQ_MORE      = 8'h80;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PC_VLQ,
        ST_PC_STAT,
        ST_PC_PROG,
        ST_NOTE_VLQ,
        ST_NOTE_STAT,
        ST_PITCH,
        ST_VEL,
        ST_EOT0,
        ST_EOT1,
        ST_EOT2,
        ST_EOT3
    } ctrl_state_t;

    typedef enum logic [2:0] {
        SEL_VLQ,
        SEL_PC_STAT,
        SEL_PROG,
        SEL_NOTE_STAT,
        SEL_PITCH,
        SEL_VEL,
        SEL_META,
        SEL_END_TRK
    } byte_sel_t;

    typedef struct packed {
        logic      load;        // latch input item
        logic      search;      // examine one channel entry
        logic      emit;        // load output register with one byte
        byte_sel_t sel;
        logic      last;        // final byte of this item
        logic      zero_delta;  // note-on after program change uses delta 0
        logic      zero_byte;   // emit literal 0x00 (end of track)
    } mnee_cmd_t;

    typedef struct packed {
        logic in_eot;
        logic hit;          // current entry matches instrument
        logic search_done;  // match found or last entry examined
        logic vlq_last;     // current VLQ group is the final one
        logic out_free;     // output register can take a byte
    } mnee_stat_t;

endpackage

>>> sv/midi_note_event_encoder_core.sv
// MIDI note event encoder, top level. Each accepted item is a note event or
// an end-of-track command and yields a run of MIDI track bytes, one per
// output item, the final one flagged by m_last_byte and each carrying the
// running track byte count. A note event first searches the channel table
// one entry per clock, stopping at the first entry holding the instrument; on
// a miss the least-used channel is taken and a program change (delta VLQ,
// 0xC0|ch, program) precedes the note-on (delta VLQ, 0x90|ch, pitch,
// velocity), whose delta is then zero. Time going backwards gives delta zero.
// End of track emits 00 FF 2F 00. After the search, bytes leave at one per
// clock while m_ready is high; a note event yields 4 to 10 bytes and end of
// track 4. One item is in work at a time: s_ready is high only while the
// sequencer is idle, which it reaches as soon as the last byte is loaded into
// the output register. Depends on mnee_pkg, mnee_ctrl and mnee_dp.
module midi_note_event_encoder_core import mnee_pkg::*; #(
    parameter int CHANNEL_COUNT = MNEE_CHANNEL_COUNT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [TIME_W-1:0]  s_event_time,
    input  logic [INSTR_W-1:0] s_instrument,
    input  logic [NOTE_W-1:0]  s_pitch,
    input  logic [NOTE_W-1:0]  s_velocity,
    // track bytes
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last_byte,
    output logic [TOTAL_W-1:0] m_track_bytes
);

    mnee_cmd_t  cmd;
    mnee_stat_t stat;

    // sequencer: idle, channel search, then one state per emitted byte (a VLQ state per delta, holding for each group)
    mnee_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // channel table, time/count state, byte formatting, output register
    mnee_dp #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_action      (s_action),
        .s_event_time  (s_event_time),
        .s_instrument  (s_instrument),
        .s_pitch       (s_pitch),
        .s_velocity    (s_velocity),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_byte   (m_last_byte),
        .m_track_bytes (m_track_bytes),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

>>> sv/mnee_ctrl.sv
// Controller for the MIDI note event encoder: sequences search and byte
// emission. Depends on mnee_pkg.
module mnee_ctrl import mnee_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  mnee_stat_t stat,
    output mnee_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = stat.in_eot ? ST_EOT0 : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (stat.search_done) begin
                    state_next = stat.hit ? ST_NOTE_VLQ : ST_PC_VLQ;
                end
            end
            ST_PC_VLQ:    if (stat.out_free && stat.vlq_last) state_next = ST_PC_STAT;
            ST_PC_STAT:   if (stat.out_free) state_next = ST_PC_PROG;
            ST_PC_PROG:   if (stat.out_free) state_next = ST_NOTE_VLQ;
            ST_NOTE_VLQ:  if (stat.out_free && stat.vlq_last) state_next = ST_NOTE_STAT;
            ST_NOTE_STAT: if (stat.out_free) state_next = ST_PITCH;
            ST_PITCH:     if (stat.out_free) state_next = ST_VEL;
            ST_VEL:       if (stat.out_free) state_next = ST_IDLE;
            ST_EOT0:      if (stat.out_free) state_next = ST_EOT1;
            ST_EOT1:      if (stat.out_free) state_next = ST_EOT2;
            ST_EOT2:      if (stat.out_free) state_next = ST_EOT3;
            ST_EOT3:      if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd            = '0;
        cmd.sel        = SEL_VLQ;
        s_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SEARCH: begin
                cmd.search = 1'b1;
            end
            ST_PC_VLQ: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_VLQ;
            end
            ST_PC_STAT: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_PC_STAT;
            end
            ST_PC_PROG: begin
                cmd.emit       = stat.out_free;
                cmd.sel        = SEL_PROG;
                cmd.zero_delta = stat.out_free;
            end
            ST_NOTE_VLQ: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_VLQ;
            end
            ST_NOTE_STAT: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_NOTE_STAT;
            end
            ST_PITCH: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_PITCH;
            end
            ST_VEL: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_VEL;
                cmd.last = 1'b1;
            end
            ST_EOT0: begin
                cmd.emit      = stat.out_free;
                cmd.sel       = SEL_META;
                cmd.zero_byte = 1'b1;
            end
            ST_EOT1: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_META;
            end
            ST_EOT2: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_END_TRK;
            end
            ST_EOT3: begin
                cmd.emit      = stat.out_free;
                cmd.sel       = SEL_END_TRK;
                cmd.zero_byte = 1'b1;
                cmd.last      = 1'b1;
            end
            default: begin
                cmd.sel = SEL_VLQ;
            end
        endcase
    end

endmodule

>>> sv/mnee_dp.sv
// Datapath for the MIDI note event encoder: input latch, channel table,
// sequential channel search, VLQ/byte formatting and output register.
// Depends on mnee_pkg.
module mnee_dp import mnee_pkg::*; #(
    parameter int CHANNEL_COUNT = MNEE_CHANNEL_COUNT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_action,
    input  logic [TIME_W-1:0]  s_event_time,
    input  logic [INSTR_W-1:0] s_instrument,
    input  logic [NOTE_W-1:0]  s_pitch,
    input  logic [NOTE_W-1:0]  s_velocity,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last_byte,
    output logic [TOTAL_W-1:0] m_track_bytes,
    input  mnee_cmd_t          cmd,
    output mnee_stat_t         stat
);

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNEL_COUNT - 1);

    // channel table, one flop row per channel
    logic [INSTR_W-1:0] chan_instr_reg [CHANNEL_COUNT];
    logic [COUNT_W-1:0] chan_count_reg [CHANNEL_COUNT];

    logic [TIME_W-1:0]  prev_time_reg;
    logic [TIME_W-1:0]  delta_reg;
    logic [GRP_W-1:0]   grp_reg;
    logic [INSTR_W-1:0] instr_reg;
    logic [NOTE_W-1:0]  pitch_reg;
    logic [NOTE_W-1:0]  vel_reg;
    logic [CH_W-1:0]    idx_reg;
    logic [CH_W-1:0]    pick_reg;
    logic [COUNT_W-1:0] low_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic               m_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               last_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic [TIME_W-1:0]  delta_in;
    logic [GRP_W-1:0]   grp_in;
    logic               hit;
    logic               cur_lower;
    logic [CH_W-1:0]    pick_now;
    logic [COUNT_W-1:0] low_now;
    logic [6:0]         grp_bits;
    logic [7:0]         byte_val;
    logic [TOTAL_W-1:0] total_next;

    // clamped delta and VLQ group index (groups minus one) of the incoming item
    always_comb begin
        delta_in = (s_event_time >= prev_time_reg) ? (s_event_time - prev_time_reg) : '0;
        priority if (delta_in[27:21] != '0) grp_in = 2'd3;
        else if (delta_in[20:14] != '0)     grp_in = 2'd2;
        else if (delta_in[13:7] != '0)      grp_in = 2'd1;
        else                                grp_in = 2'd0;
    end

    // one search step
    always_comb begin
        hit       = (chan_instr_reg[idx_reg] == instr_reg);
        cur_lower = (chan_count_reg[idx_reg] < low_reg);
        pick_now  = cur_lower ? idx_reg : pick_reg;
        low_now   = cur_lower ? chan_count_reg[idx_reg] : low_reg;
    end

    always_comb begin
        unique case (grp_reg)
            2'd3:    grp_bits = delta_reg[27:21];
            2'd2:    grp_bits = delta_reg[20:14];
            2'd1:    grp_bits = delta_reg[13:7];
            default: grp_bits = delta_reg[6:0];
        endcase
    end

    always_comb begin
        unique case (cmd.sel)
            SEL_VLQ:       byte_val = (grp_reg != '0) ? (VLQ_MORE | {1'b0, grp_bits})
                                                      : {1'b0, grp_bits};
            SEL_PC_STAT:   byte_val = STAT_PROGRAM | {4'd0, 4'(ch_reg)};
            SEL_PROG:      byte_val = {1'b0, 7'(instr_reg - 8'd1)};
            SEL_NOTE_STAT: byte_val = STAT_NOTE_ON | {4'd0, 4'(ch_reg)};
            SEL_PITCH:     byte_val = {1'b0, pitch_reg};
            SEL_VEL:       byte_val = {1'b0, vel_reg};
            SEL_META:      byte_val = cmd.zero_byte ? BYTE_ZERO : META_PREFIX;
            SEL_END_TRK:   byte_val = cmd.zero_byte ? BYTE_ZERO : META_END_TRK;
            default:       byte_val = BYTE_ZERO;
        endcase
    end

    assign total_next = total_reg + 32'd1;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg <= '0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                chan_instr_reg[i] <= '0;
                chan_count_reg[i] <= '0;
            end
        end else begin
            if (cmd.load && !s_action) begin
                prev_time_reg <= s_event_time;
            end
            if (cmd.search && hit) begin
                if (chan_count_reg[idx_reg] < COUNT_MAX) begin
                    chan_count_reg[idx_reg] <= chan_count_reg[idx_reg] + 15'd1;
                end
            end else if (cmd.search && idx_reg == CH_LAST) begin
                chan_instr_reg[pick_now] <= instr_reg;
                chan_count_reg[pick_now] <= 15'd1;
            end
            if (cmd.emit) begin
                total_reg   <= total_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            delta_reg <= delta_in;
            grp_reg   <= grp_in;
            instr_reg <= s_instrument;
            pitch_reg <= s_pitch;
            vel_reg   <= s_velocity;
            idx_reg   <= '0;
            pick_reg  <= CH_LAST;
            low_reg   <= COUNT_MAX;
        end
        if (cmd.search) begin
            idx_reg  <= idx_reg + CH_W'(1);
            pick_reg <= pick_now;
            low_reg  <= low_now;
            ch_reg   <= hit ? idx_reg : pick_now;
        end
        if (cmd.emit) begin
            out_byte_reg  <= byte_val;
            last_reg      <= cmd.last;
            out_total_reg <= total_next;
            if (cmd.sel == SEL_VLQ && grp_reg != '0) begin
                grp_reg <= grp_reg - 2'd1;
            end
        end
        if (cmd.zero_delta) begin
            delta_reg <= '0;
            grp_reg   <= '0;
        end
    end

    always_comb begin
        stat.in_eot      = s_action;
        stat.hit         = hit;
        stat.search_done = hit || (idx_reg == CH_LAST);
        stat.vlq_last    = (grp_reg == '0);
        stat.out_free    = !m_valid_reg || m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_last_byte   = last_reg;
    assign m_track_bytes = out_total_reg;

endmodule
